// File: rtl/ssort_pkg.sv
// Shared types and constants for the selection sort engine.
// No dependencies; every other file in rtl/ imports this package.
package ssort_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;
  } out_item_t;

  // Control from the sequencer to the minimum tracker.
  typedef struct packed {
    logic start;  // first read data of a pass: load the base entry
    logic valid;  // read data present this cycle
  } scan_ctl_t;

endpackage

// File: rtl/ssort_minscan.sv
// Shared signed compare unit that tracks the running minimum of one pass.
// Depends on ssort_pkg.
module ssort_minscan #(
  parameter int CW = 6
) (
  input  logic                           clk,
  input  ssort_pkg::scan_ctl_t           ctl,
  input  logic [ssort_pkg::DATA_W-1:0]   data,
  input  logic [CW-1:0]                  idx,
  output logic [ssort_pkg::DATA_W-1:0]   min_val,
  output logic [CW-1:0]                  min_idx,
  output logic [ssort_pkg::DATA_W-1:0]   base_val
);
  import ssort_pkg::*;

  logic [DATA_W-1:0] min_val_r;
  logic [CW-1:0]     min_idx_r;
  logic [DATA_W-1:0] base_val_r;
  logic              less;

  // Strict less-than keeps the first minimum found on ties.
  assign less = $signed(data) < $signed(min_val_r);

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      min_val_r  <= data;
      min_idx_r  <= idx;
      base_val_r <= data;
    end else if (ctl.valid && less) begin
      min_val_r <= data;
      min_idx_r <= idx;
    end
  end

  assign min_val  = min_val_r;
  assign min_idx  = min_idx_r;
  assign base_val = base_val_r;

endmodule

// File: rtl/selection_sort_engine_unit.sv
// Selection sort engine: top level with element memory and pass sequencer.
// Depends on ssort_pkg and ssort_minscan.
//
// The block collects signed 32-bit items into a DEPTH-entry memory, one item
// per cycle while loading. The item with last_in set closes the set; items
// arriving while the memory is full are dropped and every result of that set
// then carries overflow. The set of n entries is then sorted in place in
// ascending signed order by selection sort, and the n sorted values are sent
// out, the final one with last_out set. in_stall is high from closing a set
// until the final result is loaded into the output register; the next set can
// start loading while that final result still waits to be taken. Timing is
// set by the single read port of the element memory, which delivers one entry
// per cycle to one shared compare unit: the pass for position p reads the base
// entry, has the compare unit take each entry from the base to the end, and
// makes two swap writes. Each result is read from memory and then loaded into
// the output register, where out_stall can hold it, before the next result is
// read. No clearing pass is needed after reset.
module selection_sort_engine_unit #(
  parameter int DEPTH = ssort_pkg::DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ssort_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ssort_pkg::out_item_t  out_item
);
  import ssort_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [2:0] {
    S_LOAD,   // accept items into memory
    S_START,  // read the base entry of a pass
    S_SCAN,   // stream remaining entries through the compare unit
    S_SWAP1,  // write base value to the minimum's slot
    S_SWAP2,  // write minimum to the base slot
    S_ORD,    // read the next sorted entry
    S_OLD     // load it into the output register
  } state_t;

  // Element memory, one write and one registered read port.
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              we;
  logic [AW-1:0]     wa;
  logic [DATA_W-1:0] wd;
  logic              re;
  logic [AW-1:0]     ra;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          dropped_r, dropped_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          rdv_r, rdv_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic              in_acc;
  logic              full;
  logic              last_data;
  scan_ctl_t         scan_ctl;
  logic [DATA_W-1:0] min_val;
  logic [CW-1:0]     min_idx;
  logic [DATA_W-1:0] base_val;

  assign in_stall  = (state_r != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign full      = (count_r == DEPTH_C);
  assign last_data = rdv_r && (rd_idx_r == n_r - ONE_C);

  assign scan_ctl.start = rdv_r && (rd_idx_r == pos_r);
  assign scan_ctl.valid = rdv_r;

  ssort_minscan #(
    .CW(CW)
  ) u_minscan (
    .clk      (clk),
    .ctl      (scan_ctl),
    .data     (rd_data_r),
    .idx      (rd_idx_r),
    .min_val  (min_val),
    .min_idx  (min_idx),
    .base_val (base_val)
  );

  // Memory port selection.
  always_comb begin
    we = 1'b0;
    wa = count_r[AW-1:0];
    wd = in_item.value;
    re = 1'b0;
    ra = pos_r[AW-1:0];
    case (state_r)
      S_LOAD: begin
        we = in_acc && !full;
      end
      S_START: begin
        re = (pos_r + ONE_C) < n_r;
      end
      S_SCAN: begin
        re = ptr_r < n_r;
        ra = ptr_r[AW-1:0];
      end
      S_SWAP1: begin
        we = 1'b1;
        wa = min_idx[AW-1:0];
        wd = base_val;
      end
      S_SWAP2: begin
        we = 1'b1;
        wa = pos_r[AW-1:0];
        wd = min_val;
      end
      S_ORD: begin
        re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    ovf_nxt       = ovf_r;
    n_nxt         = n_r;
    pos_nxt       = pos_r;
    ptr_nxt       = ptr_r;
    rdv_nxt       = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (!full) begin
            count_nxt = count_r + ONE_C;
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_item.last_in) begin
            // Close the set; memory keeps the entries, counters restart.
            n_nxt       = full ? count_r : count_r + ONE_C;
            ovf_nxt     = dropped_r || full;
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            pos_nxt     = '0;
            state_nxt   = S_START;
          end
        end
      end
      S_START: begin
        if ((pos_r + ONE_C) < n_r) begin
          rdv_nxt    = 1'b1;
          rd_idx_nxt = pos_r;
          ptr_nxt    = pos_r + ONE_C;
          state_nxt  = S_SCAN;
        end else begin
          pos_nxt   = '0;
          state_nxt = S_ORD;
        end
      end
      S_SCAN: begin
        if (ptr_r < n_r) begin
          rdv_nxt    = 1'b1;
          rd_idx_nxt = ptr_r;
          ptr_nxt    = ptr_r + ONE_C;
        end
        if (last_data) begin
          state_nxt = S_SWAP1;
        end
      end
      S_SWAP1: begin
        state_nxt = S_SWAP2;
      end
      S_SWAP2: begin
        pos_nxt   = pos_r + ONE_C;
        state_nxt = S_START;
      end
      S_ORD: begin
        state_nxt = S_OLD;
      end
      S_OLD: begin
        // Load only when the output register is free or being taken.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_nxt.sorted_value = $signed(rd_data_r);
          out_nxt.last_out     = (pos_r == n_r - ONE_C);
          out_nxt.overflow     = ovf_r;
          if (pos_r == n_r - ONE_C) begin
            state_nxt = S_LOAD;
          end else begin
            pos_nxt   = pos_r + ONE_C;
            state_nxt = S_ORD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ovf_r    <= ovf_nxt;
    n_r      <= n_nxt;
    pos_r    <= pos_nxt;
    ptr_r    <= ptr_nxt;
    rd_idx_r <= rd_idx_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for selection_sort_engine_unit: directed table, then random sets.
// Depends on ssort_pkg and the RTL of the sort engine; predicts every sorted result itself.
module tb_top;
  import ssort_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7fff_ffff;
  // Long receiver hold, so the engine finishes a set and then blocks new items.
  localparam int HOLD_CYCLES = 400;
  // Quiet time after the last result; covers a full sort of the largest set.
  localparam int DRAIN_CYCLES = 800;
  // Random items per phase, before the phase's sets are closed off.
  localparam int PHASE_ITEMS = 62;

  // One row of the directed table. Rows with typed set carry their own result.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_in;
    logic                     typed;
    logic signed [DATA_W-1:0] want_value;
    logic                     want_last;
    logic                     want_ovf;
  } sort_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;

  // Predictor state: the values of the open set and whether any were dropped.
  logic signed [DATA_W-1:0] held_values [DEPTH];
  int          held_count = 0;
  bit          dropped_seen = 1'b0;
  out_item_t   expected_sorted [$];

  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_asks = 0;

  sort_row_t   sort_rows [14] = '{
    // Single-element sets: the value comes straight back, closing the set.
    '{S_MIN, 1'b1, 1'b1, S_MIN, 1'b1, 1'b0},
    '{S_MAX, 1'b1, 1'b1, S_MAX, 1'b1, 1'b0},
    '{32'sd0, 1'b1, 1'b1, 32'sd0, 1'b1, 1'b0},
    '{-32'sd1, 1'b1, 1'b1, -32'sd1, 1'b1, 1'b0},
    // Extremes together with ties.
    '{32'sd7, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{S_MAX, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{-32'sd3, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'sd7, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{S_MIN, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'sd0, 1'b1, 1'b0, '0, 1'b0, 1'b0},
    // Two negatives arriving in descending order.
    '{-32'sd2, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{-32'sd5, 1'b1, 1'b0, '0, 1'b0, 1'b0},
    // Alternating bit patterns: every data bit takes both values.
    '{32'sh5555_5555, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'shAAAA_AAAA, 1'b1, 1'b0, '0, 1'b0, 1'b0}
  };

  selection_sort_engine_unit #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the engine hangs or loses a handshake.
  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

  // Fold one accepted item into the open set. On the closing item, sort the set
  // by selection sort and queue its results; a typed row queues its own result.
  task automatic absorb_element(input in_item_t it, input bit typed, input out_item_t want);
    logic signed [DATA_W-1:0] lowest;
    int                       low_at;
    out_item_t                res;
    if (held_count < DEPTH) begin
      held_values[held_count] = it.value;
      held_count++;
    end else begin
      // Store full: drop the value, even a closing one, and flag the set.
      dropped_seen = 1'b1;
    end
    if (it.last_in) begin
      for (int pos = 0; pos + 1 < held_count; pos++) begin
        lowest = held_values[pos];
        low_at = pos;
        for (int scan = pos + 1; scan < held_count; scan++) begin
          if (held_values[scan] < lowest) begin
            lowest = held_values[scan];
            low_at = scan;
          end
        end
        held_values[low_at] = held_values[pos];
        held_values[pos] = lowest;
      end
      if (typed) begin
        expected_sorted.push_back(want);
      end else begin
        for (int k = 0; k < held_count; k++) begin
          res.sorted_value = held_values[k];
          res.last_out = (k + 1 == held_count);
          res.overflow = dropped_seen;
          expected_sorted.push_back(res);
        end
      end
      held_count = 0;
      dropped_seen = 1'b0;
    end
  endtask

  // Offer one item from the falling edge; hold it until the engine takes it.
  task automatic offer_item(input in_item_t it, input bit typed, input out_item_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    // Sample the handshake at the rising edge, before the engine's registers move.
    do @(posedge clk); while (in_stall);
    absorb_element(it, typed, want);
    @(negedge clk);
  endtask

  // Full-range values half the time, with extremes and a narrow band that forces ties.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return S_MIN;
      1: return S_MAX;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return $signed($urandom_range(6)) - 32'sd3;
      default: return $urandom;
    endcase
  endfunction

  // Mostly short sets; now and then a long one that nearly fills the store.
  function automatic int pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return $urandom_range(6, 1);
    if (roll < 95) return $urandom_range(20, 7);
    return $urandom_range(DEPTH - 1, 21);
  endfunction

  task automatic send_set(input int len);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      it.value = pick_value();
      it.last_in = (i + 1 == len);
      offer_item(it, 1'b0, '0);
    end
  endtask

  // Park the sender until every queued result has come out.
  task automatic wait_drained();
    while (expected_sorted.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold whenever the sender asks for it.
  initial begin : result_sink
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_asks > holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Compare each accepted result, field by field, with the oldest expectation.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sorted.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got value %0d last %0b ovf %0b",
                 $time, out_item.sorted_value, out_item.last_out, out_item.overflow);
      end else begin
        want = expected_sorted.pop_front();
        if (out_item.sorted_value !== want.sorted_value) begin
          errors++;
          $display("%0t: sorted_value expected %0d got %0d",
                   $time, want.sorted_value, out_item.sorted_value);
        end
        if (out_item.last_out !== want.last_out) begin
          errors++;
          $display("%0t: last_out expected %0b got %0b",
                   $time, want.last_out, out_item.last_out);
        end
        if (out_item.overflow !== want.overflow) begin
          errors++;
          $display("%0t: overflow expected %0b got %0b",
                   $time, want.overflow, out_item.overflow);
        end
      end
    end
  end

  initial begin : stimulus
    in_item_t  it;
    out_item_t want;
    int        phase_items;
    int        len;

    // Hold reset, then release it on a falling edge.
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table, sent back to back with no idling.
    foreach (sort_rows[i]) begin
      it.value = sort_rows[i].value;
      it.last_in = sort_rows[i].last_in;
      want.sorted_value = sort_rows[i].want_value;
      want.last_out = sort_rows[i].want_last;
      want.overflow = sort_rows[i].want_ovf;
      offer_item(it, sort_rows[i].typed, want);
    end
    in_valid <= 1'b0;
    wait_drained();
    @(negedge clk);

    // Random sets in three phases: sender busy and receiver often stalling, then
    // the reverse, then no random idling but one long output hold. Drain between phases.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 8;
          recv_stall_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_stall_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          // Hold the output for a long stretch while sets keep arriving.
          hold_asks++;
        end
      endcase
      phase_items = 0;
      if (ph == 0) begin
        // Fill the store exactly: nothing dropped.
        send_set(DEPTH);
        phase_items += DEPTH;
      end else if (ph == 1) begin
        // Overrun the store: the closing item is dropped but still closes the set.
        len = DEPTH + $urandom_range(4, 1);
        send_set(len);
        phase_items += len;
      end
      while (phase_items < PHASE_ITEMS) begin
        len = pick_length();
        send_set(len);
        phase_items += len;
      end
      in_valid <= 1'b0;
      wait_drained();
      @(negedge clk);
    end

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
